/* hw/rtl/sync_frame_receiver_with_timeout_top_defines.svh */
// assertion macros used by the sync frame receiver frame core
`ifndef SYNC_FRAME_RECEIVER_WITH_TIMEOUT_TOP_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_WITH_TIMEOUT_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/sfr_pkg.sv */
// types and constants of the sync frame receiver
package sfr_pkg;

   localparam logic [7:0] SYNC_RESET    = 8'h7E;
   localparam logic [7:0] TIMEOUT_RESET = 8'd10;
   localparam logic [7:0] CHECK_MASK    = 8'h7F;
   localparam logic [7:0] TICK_MAX      = 8'hFF;
   localparam logic [2:0] POS_IDLE      = 3'd0;
   localparam logic [2:0] POS_LAST_DATA = 3'd4;
   localparam logic [2:0] POS_SPARE     = 3'd5;
   localparam int         CSR_IDX_W     = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC    = 1'b0,
      CSR_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic {
      FUNC_BYTE = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       link_ok;
      logic       frame_accepted;
      logic [7:0] signal_byte;
      logic [7:0] switch_byte;
      logic [7:0] flex_switch_byte;
   } status_type;

endpackage

/* hw/rtl/sfr_in_stage.sv */
// input register of the sync frame receiver
module sfr_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfr_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output sfr_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   sfr_pkg::item_type item_ff;
   logic              take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hw/rtl/sfr_frame_core.sv */
// frame assembly, check, link timeout and status of the sync frame receiver
`include "sync_frame_receiver_with_timeout_top_defines.svh"

module sfr_frame_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  sfr_pkg::item_type   item,
   input  logic [7:0]          sync_byte,
   input  logic [7:0]          timeout_ticks,
   output sfr_pkg::status_type status
);

   logic [2:0] pos_ff;
   logic [2:0] pos_in;
   logic [7:0] bytes_ff [4];
   logic [7:0] bytes_in [4];
   logic [7:0] signal_ff;
   logic [7:0] signal_in;
   logic [7:0] switch_ff;
   logic [7:0] switch_in;
   logic [7:0] flex_ff;
   logic [7:0] flex_in;
   logic       ok_ff;
   logic       ok_in;
   logic [7:0] tick_ff;
   logic [7:0] tick_in;
   logic [7:0] tick_inc;
   logic [1:0] wr_idx;
   logic [7:0] check;
   logic       accepted;

   assign wr_idx   = 2'(pos_ff - 3'd1);
   assign check    = ~8'(bytes_ff[0] + bytes_ff[1] + bytes_ff[2]) & sfr_pkg::CHECK_MASK;
   assign tick_inc = (tick_ff == sfr_pkg::TICK_MAX) ? tick_ff : 8'(tick_ff + 8'd1);

   always_comb begin
      pos_in    = pos_ff;
      bytes_in  = bytes_ff;
      signal_in = signal_ff;
      switch_in = switch_ff;
      flex_in   = flex_ff;
      ok_in     = ok_ff;
      tick_in   = tick_ff;
      accepted  = 1'b0;
      case (item.func)
         sfr_pkg::FUNC_TICK: begin
            tick_in = tick_inc;
            if (tick_inc > timeout_ticks) begin
               ok_in = 1'b0;
            end
         end
         sfr_pkg::FUNC_BYTE: begin
            if (pos_ff == sfr_pkg::POS_IDLE) begin
               if (item.rx_byte == sync_byte) begin
                  pos_in = 3'd1;
               end
            end else if (pos_ff == sfr_pkg::POS_SPARE) begin
               // sixth byte is the spare, frame is complete
               pos_in = sfr_pkg::POS_IDLE;
               if (check == bytes_ff[3]) begin
                  accepted  = 1'b1;
                  signal_in = bytes_ff[0];
                  switch_in = bytes_ff[1];
                  flex_in   = bytes_ff[2];
                  ok_in     = 1'b1;
                  tick_in   = 8'd0;
               end
            end else begin
               if (pos_ff <= sfr_pkg::POS_LAST_DATA) begin
                  bytes_in[wr_idx] = item.rx_byte;
               end
               pos_in = 3'(pos_ff + 3'd1);
            end
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= sfr_pkg::POS_IDLE;
         signal_ff <= 8'd0;
         switch_ff <= 8'd0;
         flex_ff   <= 8'd0;
         ok_ff     <= 1'b0;
         tick_ff   <= 8'd0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         signal_ff <= signal_in;
         switch_ff <= switch_in;
         flex_ff   <= flex_in;
         ok_ff     <= ok_in;
         tick_ff   <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         bytes_ff <= bytes_in;
      end
   end

   // snapshot after this item
   assign status.link_ok          = ok_in;
   assign status.frame_accepted   = accepted;
   assign status.signal_byte      = signal_in;
   assign status.switch_byte      = switch_in;
   assign status.flex_switch_byte = flex_in;

   `SFR_ASSERT_NOW(a_pos_range, 1'b1, pos_ff <= sfr_pkg::POS_SPARE,
      "frame position out of range")
   `SFR_ASSERT_NEXT(a_accept_effect, fire && accepted, ok_ff && tick_ff == 8'd0,
      "good frame did not set link and clear ticks")
   `SFR_ASSERT_NOW(a_ok_rise, $rose(ok_ff), $past(fire && accepted),
      "link ok set without a good frame")
   `SFR_ASSERT_NEXT(a_tick_mono, fire && item.func == sfr_pkg::FUNC_TICK,
      tick_ff >= $past(tick_ff), "tick counter went down on a tick")

endmodule

/* hw/rtl/sfr_out_stage.sv */
// result register of the sync frame receiver
module sfr_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sfr_pkg::status_type status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                can_load,
   output sfr_pkg::status_type rsp_status
);

   logic                valid_ff;
   logic                valid_in;
   sfr_pkg::status_type status_ff;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;

endmodule

/* hw/rtl/sync_frame_receiver_with_timeout_top.sv */
// Sync frame receiver with link timeout. Each req transfer is a received byte (func 0)
// or a 10 ms tick (func 1); each one yields exactly one rsp transfer carrying the status
// after that item. One item is taken every cycle while rsp is not stalled: the item sits
// in an input register, one pass of frame logic updates the state and loads the result
// register, which drives rsp; a full result register that is not taken holds both.
// req_ready follows rsp_ready combinationally through both registers. csr_index 0
// writes the sync byte (reset 0x7E), 1 the timeout in ticks (reset 10); write them only
// while no item is in flight.
module sync_frame_receiver_with_timeout_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_link_ok,
   output logic                           rsp_frame_accepted,
   output logic [7:0]                     rsp_signal_byte,
   output logic [7:0]                     rsp_switch_byte,
   output logic [7:0]                     rsp_flex_switch_byte,
   input  logic                           csr_wen,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                     csr_wdata
);

   logic [7:0]          sync_ff;
   logic [7:0]          timeout_ff;
   sfr_pkg::item_type   req_item;
   sfr_pkg::item_type   item;
   logic                item_valid;
   logic                can_load;
   logic                fire;
   sfr_pkg::status_type status;
   sfr_pkg::status_type rsp_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= sfr_pkg::SYNC_RESET;
         timeout_ff <= sfr_pkg::TIMEOUT_RESET;
      end else if (csr_wen) begin
         case (sfr_pkg::csr_index_type'(csr_index))
            sfr_pkg::CSR_SYNC:    sync_ff    <= csr_wdata;
            sfr_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
            default:              sync_ff    <= sync_ff;
         endcase
      end
   end

   assign req_item.func    = sfr_pkg::func_type'(req_func);
   assign req_item.rx_byte = req_rx_byte;
   assign fire             = item_valid && can_load;

   sfr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (can_load),
      .item_valid (item_valid),
      .item       (item)
   );

   sfr_frame_core u_frame_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .item          (item),
      .sync_byte     (sync_ff),
      .timeout_ticks (timeout_ff),
      .status        (status)
   );

   sfr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .status     (status),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .can_load   (can_load),
      .rsp_status (rsp_status)
   );

   assign rsp_link_ok          = rsp_status.link_ok;
   assign rsp_frame_accepted   = rsp_status.frame_accepted;
   assign rsp_signal_byte      = rsp_status.signal_byte;
   assign rsp_switch_byte      = rsp_status.switch_byte;
   assign rsp_flex_switch_byte = rsp_status.flex_switch_byte;

endmodule

/* tb/sv/sync_frame_receiver_with_timeout_top_tb.sv */
// self-checking testbench for the sync frame receiver with link timeout
`timescale 1ns / 1ps

module sync_frame_receiver_with_timeout_top_tb;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 4;    // two register stages plus margin
   localparam int LONG_HOLD     = 120;
   localparam int TICK_BURST    = 260;  // enough ticks to saturate the counter

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_func = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_link_ok;
   logic       rsp_frame_accepted;
   logic [7:0] rsp_signal_byte;
   logic [7:0] rsp_switch_byte;
   logic [7:0] rsp_flex_switch_byte;
   logic       csr_wen = 1'b0;
   logic [sfr_pkg::CSR_IDX_W-1:0] csr_index = sfr_pkg::CSR_SYNC;
   logic [7:0] csr_wdata = 8'h00;

   sync_frame_receiver_with_timeout_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_link_ok          (rsp_link_ok),
      .rsp_frame_accepted   (rsp_frame_accepted),
      .rsp_signal_byte      (rsp_signal_byte),
      .rsp_switch_byte      (rsp_switch_byte),
      .rsp_flex_switch_byte (rsp_flex_switch_byte),
      .csr_wen              (csr_wen),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sfr_pkg::item_type   pending_items[$];
   sfr_pkg::status_type expected_status[$];
   int         error_count = 0;
   int         cycle_count = 0;
   int         send_idle_pct = 7;
   int         recv_idle_pct = 85;
   int         hold_requests = 0;
   int         hold_served = 0;
   int         hold_left = 0;
   logic       req_taken = 1'b0;

   // receiver state as the testbench sees it
   logic [7:0] cfg_sync = sfr_pkg::SYNC_RESET;
   logic [7:0] cfg_timeout = sfr_pkg::TIMEOUT_RESET;
   logic [2:0] rx_pos = sfr_pkg::POS_IDLE;
   logic [7:0] frame_buf [0:3] = '{8'h00, 8'h00, 8'h00, 8'h00};
   logic [7:0] held_signal = 8'h00;
   logic [7:0] held_switch = 8'h00;
   logic [7:0] held_flex = 8'h00;
   logic       link_flag = 1'b0;
   logic [7:0] tick_cnt = 8'h00;

   function automatic logic [7:0] frame_check(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      logic [7:0] sum;
      sum = a + b + c;
      return ~sum & sfr_pkg::CHECK_MASK;
   endfunction

   task automatic advance_receiver(input sfr_pkg::item_type it,
                                   output sfr_pkg::status_type st);
      logic accepted;
      accepted = 1'b0;
      if (it.func == sfr_pkg::FUNC_TICK) begin
         if (tick_cnt != sfr_pkg::TICK_MAX)
            tick_cnt = tick_cnt + 8'd1;
         if (tick_cnt > cfg_timeout)
            link_flag = 1'b0;
      end else if (rx_pos == sfr_pkg::POS_IDLE) begin
         if (it.rx_byte == cfg_sync)
            rx_pos = sfr_pkg::POS_IDLE + 3'd1;
      end else begin
         if (rx_pos <= sfr_pkg::POS_LAST_DATA)
            frame_buf[2'(rx_pos - 3'd1)] = it.rx_byte;
         // spare byte closes the frame, its value is don't-care
         if (rx_pos == sfr_pkg::POS_SPARE) begin
            if (frame_check(frame_buf[0], frame_buf[1], frame_buf[2]) == frame_buf[3]) begin
               held_signal = frame_buf[0];
               held_switch = frame_buf[1];
               held_flex = frame_buf[2];
               link_flag = 1'b1;
               tick_cnt = 8'h00;
               accepted = 1'b1;
            end
            rx_pos = sfr_pkg::POS_IDLE;
         end else begin
            rx_pos = rx_pos + 3'd1;
         end
      end
      st.link_ok = link_flag;
      st.frame_accepted = accepted;
      st.signal_byte = held_signal;
      st.switch_byte = held_switch;
      st.flex_switch_byte = held_flex;
   endtask

   task automatic queue_item(sfr_pkg::func_type f, logic [7:0] b);
      sfr_pkg::item_type it;
      it.func = f;
      it.rx_byte = b;
      pending_items.push_back(it);
   endtask

   // tick_slot 1..5 puts a tick ahead of that frame byte, -1 for none
   task automatic queue_frame(logic [7:0] p1, logic [7:0] p2, logic [7:0] p3,
                              logic [7:0] chk, logic [7:0] spare, int tick_slot);
      logic [7:0] seq [0:5];
      seq = '{cfg_sync, p1, p2, p3, chk, spare};
      for (int i = 0; i < 6; i++) begin
         if (i == tick_slot)
            queue_item(sfr_pkg::FUNC_TICK, 8'($urandom_range(255)));
         queue_item(sfr_pkg::FUNC_BYTE, seq[i]);
      end
   endtask

   task automatic queue_random(int count);
      int         target;
      int         pick;
      int         slot;
      logic [7:0] p1, p2, p3;
      target = pending_items.size() + count;
      while (pending_items.size() < target) begin
         pick = int'($urandom_range(99));
         p1 = 8'($urandom_range(255));
         p2 = 8'($urandom_range(255));
         p3 = 8'($urandom_range(255));
         slot = ($urandom_range(99) < 15) ? int'($urandom_range(5, 1)) : -1;
         if (pick < 50) begin
            queue_frame(p1, p2, p3, frame_check(p1, p2, p3), 8'($urandom_range(255)), slot);
         end else if (pick < 62) begin
            // one flipped check bit, bit 7 included
            queue_frame(p1, p2, p3, frame_check(p1, p2, p3) ^ (8'd1 << $urandom_range(7)),
                        8'($urandom_range(255)), slot);
         end else if (pick < 80) begin
            repeat ($urandom_range(15, 1))
               queue_item(sfr_pkg::FUNC_TICK, 8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(4, 1))
               queue_item(sfr_pkg::FUNC_BYTE, 8'($urandom_range(255)));
         end
      end
   endtask

   task automatic queue_ticks(int count);
      repeat (count) queue_item(sfr_pkg::FUNC_TICK, 8'($urandom_range(255)));
   endtask

   task automatic write_csr(sfr_pkg::csr_index_type idx, logic [7:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         sfr_pkg::CSR_SYNC:    cfg_sync = value;
         sfr_pkg::CSR_TIMEOUT: cfg_timeout = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_status.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sender
   always @(negedge clock) begin : driver
      sfr_pkg::item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_func <= next_item.func;
            req_rx_byte <= next_item.rx_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      sfr_pkg::item_type   seen;
      sfr_pkg::status_type want;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.func = sfr_pkg::func_type'(req_func);
            seen.rx_byte = req_rx_byte;
            advance_receiver(seen, want);
            expected_status.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               $error("status transfer with nothing expected");
               error_count++;
            end else begin
               want = expected_status.pop_front();
               if (rsp_link_ok !== want.link_ok) begin
                  $error("link_ok: expected %0h, got %0h", want.link_ok, rsp_link_ok);
                  error_count++;
               end
               if (rsp_frame_accepted !== want.frame_accepted) begin
                  $error("frame_accepted: expected %0h, got %0h",
                         want.frame_accepted, rsp_frame_accepted);
                  error_count++;
               end
               if (rsp_signal_byte !== want.signal_byte) begin
                  $error("signal_byte: expected %0h, got %0h",
                         want.signal_byte, rsp_signal_byte);
                  error_count++;
               end
               if (rsp_switch_byte !== want.switch_byte) begin
                  $error("switch_byte: expected %0h, got %0h",
                         want.switch_byte, rsp_switch_byte);
                  error_count++;
               end
               if (rsp_flex_switch_byte !== want.flex_switch_byte) begin
                  $error("flex_switch_byte: expected %0h, got %0h",
                         want.flex_switch_byte, rsp_flex_switch_byte);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle bytes, sync inside payload, bad check with bit 7 set,
      // tick inside a frame, then ticks past the reset timeout
      queue_item(sfr_pkg::FUNC_TICK, 8'hFF);
      queue_item(sfr_pkg::FUNC_BYTE, 8'h00);
      queue_item(sfr_pkg::FUNC_BYTE, 8'hFF);
      queue_frame(8'hFF, 8'h00, sfr_pkg::SYNC_RESET,
                  frame_check(8'hFF, 8'h00, sfr_pkg::SYNC_RESET), 8'hFF, -1);
      queue_frame(8'h01, 8'h80, 8'h7F, frame_check(8'h01, 8'h80, 8'h7F) | 8'h80, 8'h00, 3);
      queue_ticks(11);
      wait_drained();

      write_csr(sfr_pkg::CSR_SYNC, 8'h00);
      write_csr(sfr_pkg::CSR_TIMEOUT, 8'h00);
      queue_random(180);
      wait_drained();

      send_idle_pct = 85;
      recv_idle_pct = 7;
      write_csr(sfr_pkg::CSR_SYNC, 8'hFF);
      write_csr(sfr_pkg::CSR_TIMEOUT, 8'd254);
      queue_random(90);
      queue_ticks(TICK_BURST);
      queue_random(90);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(sfr_pkg::CSR_SYNC, 8'($urandom_range(255)));
      write_csr(sfr_pkg::CSR_TIMEOUT, 8'($urandom_range(20, 1)));
      queue_random(180);
      hold_requests++;
      wait_drained();

      // timeout at all ones: link never drops on ticks
      write_csr(sfr_pkg::CSR_SYNC, 8'($urandom_range(255)));
      write_csr(sfr_pkg::CSR_TIMEOUT, 8'hFF);
      queue_random(90);
      queue_ticks(TICK_BURST);
      queue_random(90);
      hold_requests++;
      wait_drained();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
